[design/tot_pkg.sv]
package tot_pkg;

    // field and register widths
    localparam int COUNT_W  = 32;
    localparam int FREQ_W   = 28;
    localparam int TICKS_W  = 64;
    localparam int CONST_W  = 20;
    localparam int LO_W     = COUNT_W + CONST_W;
    localparam int DIVS_W   = FREQ_W + CONST_W;
    localparam int NSEC_W   = 30;
    localparam int FRAC_W   = 20;
    localparam int NSCONST_W = 10;
    localparam int CFG_IDX_W = 1;
    localparam int STEP_W   = 6;

    // time constants
    localparam logic [CONST_W-1:0]   USEC_SCALE = CONST_W'(1000000);
    localparam logic [NSCONST_W-1:0] NSEC_SCALE = NSCONST_W'(1000);

    // reset values of the configuration registers
    localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(1000000);
    localparam logic              WIDE_RESET = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICK_FREQUENCY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_COUNTER   = 1'b1;

    // request codes
    localparam logic REQ_OVERFLOW = 1'b0;
    localparam logic REQ_READ     = 1'b1;

    // last step index of each division pass
    localparam logic [STEP_W-1:0] SEC_LAST_STEP  = STEP_W'(63);
    localparam logic [STEP_W-1:0] FRAC_LAST_STEP = STEP_W'(FRAC_W - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICKS,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_DIV_SEC,
        ST_FRAC_LOAD,
        ST_DIV_FRAC,
        ST_NSEC,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic tick_calc;
        logic mul_lo;
        logic mul_hi;
        logic load_sec;
        logic div_step;
        logic load_frac;
        logic nsec_calc;
        logic out_load;
    } dp_cmd_t;

endpackage

[design/tot_ctrl.sv]
module tot_ctrl
    import tot_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    req_type,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    ctrl_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    // state, step counter and output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (req_type == REQ_READ)
                    begin
                        state_next = ST_TICKS;
                    end
                end
            end
            ST_TICKS:
            begin
                cmd.tick_calc = 1'b1;
                state_next    = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.load_sec = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV_SEC;
            end
            ST_DIV_SEC:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == SEC_LAST_STEP)
                begin
                    state_next = ST_FRAC_LOAD;
                end
            end
            ST_FRAC_LOAD:
            begin
                cmd.load_frac = 1'b1;
                step_next     = '0;
                state_next    = ST_DIV_FRAC;
            end
            ST_DIV_FRAC:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == FRAC_LAST_STEP)
                begin
                    state_next = ST_NSEC;
                end
            end
            ST_NSEC:
            begin
                cmd.nsec_calc = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

[design/tot_datapath.sv]
module tot_datapath
    import tot_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FREQ_W-1:0]    cfg_data,
    input  logic                 req_type,
    input  logic [COUNT_W-1:0]   count_first,
    input  logic                 overflow_pending,
    input  logic [COUNT_W-1:0]   count_after,
    output logic [COUNT_W-1:0]   seconds,
    output logic [NSEC_W-1:0]    nanoseconds,
    output logic                 interrupt_ack
);

    logic [FREQ_W-1:0]  freq_reg;
    logic               wide_reg;
    logic [COUNT_W-1:0] ovf_cnt_reg;

    logic [COUNT_W-1:0] ovf_use_reg, sample_reg;
    logic               ack_reg;
    logic [TICKS_W-1:0] ticks_reg;
    logic [DIVS_W-1:0]  dsec_reg;
    logic [LO_W-1:0]    lo_reg;
    logic [COUNT_W-1:0] hi_reg;
    logic [DIVS_W-1:0]  rem_reg;
    logic [TICKS_W-1:0] quot_reg;
    logic [DIVS_W-1:0]  divisor_reg;
    logic [COUNT_W-1:0] sec_reg;
    logic [NSEC_W-1:0]  nsec_reg;
    logic [COUNT_W-1:0] sec_out_reg;
    logic [NSEC_W-1:0]  nsec_out_reg;
    logic               ack_out_reg;

    logic [COUNT_W-1:0] ovf_inc;
    logic [FREQ_W-1:0]  freq_eff;
    logic [TICKS_W-1:0] ticks_next;
    logic [COUNT_W-1:0] mul_op;
    logic [LO_W-1:0]    mul_prod;
    logic [TICKS_W-1:0] scaled;
    logic [DIVS_W:0]    rem_shift;
    logic [DIVS_W:0]    div_ext;
    logic               fits;
    logic [DIVS_W:0]    rem_diff;

    // saturating increment of the overflow count
    assign ovf_inc = (ovf_cnt_reg == '1) ? ovf_cnt_reg : ovf_cnt_reg + COUNT_W'(1);

    // configuration registers and overflow count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg    <= FREQ_RESET;
            wide_reg    <= WIDE_RESET;
            ovf_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_TICK_FREQUENCY: freq_reg <= cfg_data;
                    REG_WIDE_COUNTER:   wide_reg <= cfg_data[0];
                    default:            ;
                endcase
            end
            if (cmd.capture && (req_type == REQ_OVERFLOW || overflow_pending))
            begin
                ovf_cnt_reg <= ovf_inc;
            end
        end
    end

    // a zero frequency divides as one
    assign freq_eff = (freq_reg == '0) ? FREQ_W'(1) : freq_reg;

    // extended tick count
    assign ticks_next = wide_reg ? {ovf_use_reg, sample_reg}
                                 : ({16'b0, ovf_use_reg, 16'b0} + {32'b0, sample_reg});

    // shared 32 x 20 multiplier for the two halves of ticks times one million
    assign mul_op   = cmd.mul_hi ? ticks_reg[TICKS_W-1:COUNT_W] : ticks_reg[COUNT_W-1:0];
    assign mul_prod = LO_W'(mul_op) * LO_W'(USEC_SCALE);

    // product wrapped to 64 bits
    assign scaled = {12'b0, lo_reg} + {hi_reg, 32'b0};

    // one restoring division step
    assign rem_shift = {rem_reg, quot_reg[TICKS_W-1]};
    assign div_ext   = {1'b0, divisor_reg};
    assign fits      = rem_shift >= div_ext;
    assign rem_diff  = rem_shift - div_ext;

    // arithmetic pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ovf_use_reg <= overflow_pending ? ovf_inc : ovf_cnt_reg;
            sample_reg  <= overflow_pending ? count_after : count_first;
            ack_reg     <= overflow_pending;
        end
        if (cmd.tick_calc)
        begin
            ticks_reg <= ticks_next;
            dsec_reg  <= DIVS_W'(freq_eff) * DIVS_W'(USEC_SCALE);
        end
        if (cmd.mul_lo)
        begin
            lo_reg <= mul_prod;
        end
        if (cmd.mul_hi)
        begin
            hi_reg <= mul_prod[COUNT_W-1:0];
        end
        // seconds pass divides by frequency times one million
        if (cmd.load_sec)
        begin
            rem_reg     <= '0;
            quot_reg    <= scaled;
            divisor_reg <= dsec_reg;
        end
        // fraction pass divides the remainder by the frequency; quotient fits 20 bits
        else if (cmd.load_frac)
        begin
            sec_reg     <= quot_reg[COUNT_W-1:0];
            rem_reg     <= {{FRAC_W{1'b0}}, rem_reg[DIVS_W-1:FRAC_W]};
            quot_reg    <= {rem_reg[FRAC_W-1:0], {(TICKS_W-FRAC_W){1'b0}}};
            divisor_reg <= {{CONST_W{1'b0}}, freq_eff};
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= fits ? rem_diff[DIVS_W-1:0] : rem_shift[DIVS_W-1:0];
            quot_reg <= {quot_reg[TICKS_W-2:0], fits};
        end
        if (cmd.nsec_calc)
        begin
            nsec_reg <= NSEC_W'(quot_reg[FRAC_W-1:0]) * NSEC_W'(NSEC_SCALE);
        end
        if (cmd.out_load)
        begin
            sec_out_reg  <= sec_reg;
            nsec_out_reg <= nsec_reg;
            ack_out_reg  <= ack_reg;
        end
    end

    assign seconds       = sec_out_reg;
    assign nanoseconds   = nsec_out_reg;
    assign interrupt_ack = ack_out_reg;

endmodule

[design/timer_overflow_timestamp.sv]
// Extends a free-running 16- or 32-bit counter with a saturating overflow count and
// turns it into seconds and nanoseconds. An overflow item gives no result. A read
// item (using the later sample and acknowledging when an overflow is pending) runs
// through these steps before its result is offered: states ST_TICKS, ST_MUL_LO,
// ST_MUL_HI and ST_SUM form the extended count and its product with one million,
// then a one-bit-per-cycle restoring divider runs 64 steps by frequency times one
// million for the seconds, ST_FRAC_LOAD sets up and 20 steps divide by the
// frequency for the microsecond fraction, followed by the nanosecond multiply and
// the output load. A new item is taken once the block is back in idle.
// The division loop sets the rate; one item is worked on at a time, and the next
// item is taken while a result waits in the output register. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
module timer_overflow_timestamp
    import tot_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FREQ_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [COUNT_W-1:0]   count_first,
    input  logic                 overflow_pending,
    input  logic [COUNT_W-1:0]   count_after,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [COUNT_W-1:0]   seconds,
    output logic [NSEC_W-1:0]    nanoseconds,
    output logic                 interrupt_ack
);

    dp_cmd_t cmd;

    // sequencer
    tot_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // count, multiply and divide datapath
    tot_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_type         (req_type),
        .count_first      (count_first),
        .overflow_pending (overflow_pending),
        .count_after      (count_after),
        .seconds          (seconds),
        .nanoseconds      (nanoseconds),
        .interrupt_ack    (interrupt_ack)
    );

endmodule

[bench/timer_overflow_timestamp_tb.sv]
module timer_overflow_timestamp_tb;
    import tot_pkg::*;

    typedef struct packed {
        logic               req;
        logic [COUNT_W-1:0] first;
        logic               pend;
        logic [COUNT_W-1:0] after;
    } stim_t;

    typedef struct packed {
        logic [COUNT_W-1:0] sec;
        logic [NSEC_W-1:0]  nsec;
        logic               ack;
    } stamp_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FREQ_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 req_type = REQ_OVERFLOW;
    logic [COUNT_W-1:0]   count_first = '0;
    logic                 overflow_pending = 1'b0;
    logic [COUNT_W-1:0]   count_after = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [COUNT_W-1:0]   seconds;
    logic [NSEC_W-1:0]    nanoseconds;
    logic                 interrupt_ack;

    // stimulus and expected timestamps
    stim_t  pending_items[$];
    stamp_t exp_stamps[$];

    // predictor state
    logic [FREQ_W-1:0]  model_freq = FREQ_RESET;
    logic               model_wide = WIDE_RESET;
    logic [COUNT_W-1:0] model_ovf = '0;

    logic [COUNT_W-1:0] tick_now = '0;
    int  errors = 0;
    int  items_taken = 0;
    int  send_wait = 0;
    int  recv_wait = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  send_idle = 1'b1;
    bit  recv_idle = 1'b1;
    stim_t next_item;
    stamp_t got_stamp;
    stamp_t want_stamp;

    timer_overflow_timestamp uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .count_first      (count_first),
        .overflow_pending (overflow_pending),
        .count_after      (count_after),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .seconds          (seconds),
        .nanoseconds      (nanoseconds),
        .interrupt_ack    (interrupt_ack)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [COUNT_W-1:0] bump_saturating(logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // extended tick count scaled to microseconds, then split into sec and ns
    function automatic stamp_t timestamp_of(logic [COUNT_W-1:0] ovf,
                                            logic [COUNT_W-1:0] sample, logic ack);
        logic [63:0] ticks;
        logic [63:0] usec;
        logic [63:0] divisor;
        logic [63:0] frac;
        logic [63:0] whole;
        stamp_t s;
        ticks   = ({32'b0, ovf} << (model_wide ? 32 : 16)) + {32'b0, sample};
        divisor = (model_freq == '0) ? 64'd1 : {36'b0, model_freq};
        usec    = (ticks * 64'd1000000) / divisor;
        frac    = (usec % 64'd1000000) * 64'd1000;
        whole   = usec / 64'd1000000;
        s.sec   = whole[COUNT_W-1:0];
        s.nsec  = frac[NSEC_W-1:0];
        s.ack   = ack;
        return s;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap(bit idle_on);
        int r;
        if (!idle_on)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 96)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 150);
    endfunction

    function automatic void note_miss(string what, logic [63:0] want, logic [63:0] got);
        errors++;
        if (errors <= 10)
        begin
            $display("mismatch %s: expected %0d got %0d", what, want, got);
        end
    endfunction

    // sender: predicts on acceptance, then offers the next item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                items_taken++;
                if (req_type == REQ_OVERFLOW)
                begin
                    model_ovf = bump_saturating(model_ovf);
                end
                else if (overflow_pending)
                begin
                    model_ovf = bump_saturating(model_ovf);
                    exp_stamps.push_back(timestamp_of(model_ovf, count_after, 1'b1));
                end
                else
                begin
                    exp_stamps.push_back(timestamp_of(model_ovf, count_first, 1'b0));
                end
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    next_item = pending_items.pop_front();
                    req_type         <= next_item.req;
                    count_first      <= next_item.first;
                    overflow_pending <= next_item.pend;
                    count_after      <= next_item.after;
                    in_valid         <= 1'b1;
                    send_wait = pick_gap(send_idle);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off once, so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && items_taken >= 300)
        begin
            hold_left <= 600;
            hold_done <= 1'b1;
        end
    end

    // receiver: checks each result against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_stamp.sec  = seconds;
                got_stamp.nsec = nanoseconds;
                got_stamp.ack  = interrupt_ack;
                if (exp_stamps.size() == 0)
                begin
                    note_miss("unexpected result, seconds", 64'd0, {32'b0, got_stamp.sec});
                end
                else
                begin
                    want_stamp = exp_stamps.pop_front();
                    if (got_stamp.sec !== want_stamp.sec)
                    begin
                        note_miss("seconds", 64'(want_stamp.sec), 64'(got_stamp.sec));
                    end
                    if (got_stamp.nsec !== want_stamp.nsec)
                    begin
                        note_miss("nanoseconds", 64'(want_stamp.nsec),
                                  64'(got_stamp.nsec));
                    end
                    if (got_stamp.ack !== want_stamp.ack)
                    begin
                        note_miss("interrupt_ack", 64'(want_stamp.ack),
                                  64'(got_stamp.ack));
                    end
                end
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (recv_idle && $urandom_range(0, 4) == 0)
                begin
                    recv_wait = pick_gap(1'b1);
                end
            end
        end
    end

    task automatic add_item(logic req, logic [COUNT_W-1:0] first, logic pend,
                            logic [COUNT_W-1:0] after);
        stim_t it;
        it.req   = req;
        it.first = first;
        it.pend  = pend;
        it.after = after;
        pending_items.push_back(it);
    endtask

    // mostly a counter running forward with wraps seen as overflows, some noise
    task automatic add_random(int n);
        logic [COUNT_W-1:0] span;
        logic [COUNT_W-1:0] stride;
        logic [COUNT_W:0]   ahead;
        logic [COUNT_W:0]   past;
        logic [COUNT_W-1:0] wrapped;
        for (int k = 0; k < n; k++)
        begin
            span     = model_wide ? 32'hFFFF_FFFF : 32'h0000_FFFF;
            tick_now = tick_now & span;
            if ($urandom_range(0, 9) < 7)
            begin
                stride = ($urandom_range(0, 3) == 0) ? ($urandom & span)
                                                      : $urandom_range(0, 4000);
                ahead   = {1'b0, tick_now} + {1'b0, stride};
                past    = ahead - {1'b0, span} - 33'd1;
                wrapped = past[COUNT_W-1:0];
                if (ahead > {1'b0, span})
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        // overflow taken as an event, then a plain read
                        add_item(REQ_OVERFLOW, $urandom, 1'($urandom_range(0, 1)),
                                 $urandom);
                        tick_now = wrapped;
                        add_item(REQ_READ, tick_now, 1'b0,
                                 (tick_now + $urandom_range(0, 50)) & span);
                    end
                    else
                    begin
                        // overflow still pending at read time
                        add_item(REQ_READ, tick_now, 1'b1, wrapped);
                        tick_now = wrapped;
                    end
                end
                else
                begin
                    tick_now = ahead[COUNT_W-1:0];
                    add_item(REQ_READ, tick_now, 1'b0,
                             (tick_now + $urandom_range(0, 50)) & span);
                end
            end
            else
            begin
                add_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                         $urandom);
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FREQ_W-1:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_TICK_FREQUENCY)
        begin
            model_freq = val;
        end
        else
        begin
            model_wide = val[0];
        end
    endtask

    // all items accepted and all results back, then the divider latency
    task automatic wait_quiet();
        while (pending_items.size() > 0 || in_valid || exp_stamps.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
    endtask

    // stimulus sequence, one configuration per phase
    initial
    begin
        logic [FREQ_W-1:0] freq_plan[8];
        logic              wide_plan[8];
        freq_plan = '{FREQ_RESET, 28'd1, 28'd0, 28'hFFF_FFFF, 28'd200000000,
                      28'd0, 28'd1000000, 28'd0};
        wide_plan = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        freq_plan[5] = FREQ_W'($urandom_range(1, 200000000));
        freq_plan[7] = FREQ_W'($urandom_range(1, 1000));
        wide_plan[7] = 1'($urandom_range(0, 1));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase > 0)
            begin
                write_reg(REG_TICK_FREQUENCY, freq_plan[phase]);
                write_reg(REG_WIDE_COUNTER, {27'b0, wide_plan[phase]});
            end
            send_idle = (phase != 2 && phase != 5);
            recv_idle = (phase != 4);
            case (phase)
                0:
                begin
                    add_item(REQ_READ, '0, 1'b0, '0);
                    add_item(REQ_READ, '1, 1'b0, $urandom);
                    add_item(REQ_READ, '1, 1'b1, '0);
                    add_item(REQ_READ, '0, 1'b1, '1);
                    add_item(REQ_OVERFLOW, '1, 1'b1, '1);
                    add_item(REQ_OVERFLOW, '0, 1'b0, '0);
                    add_item(REQ_READ, 32'h0000_FFFF, 1'b0, '1);
                    add_item(REQ_READ, 32'h8000_0000, 1'b0, '0);
                end
                1:
                begin
                    // narrow counter given a full-width sample
                    add_item(REQ_READ, '1, 1'b0, '0);
                    add_item(REQ_READ, '0, 1'b1, 32'h0000_FFFF);
                    add_item(REQ_OVERFLOW, $urandom, 1'b0, $urandom);
                    add_item(REQ_READ, 32'h0000_FFFF, 1'b0, '0);
                end
                2:
                begin
                    // zero frequency divides by one
                    add_item(REQ_READ, '1, 1'b0, '0);
                    add_item(REQ_READ, 32'd1, 1'b1, '1);
                end
                3:
                begin
                    add_item(REQ_READ, '1, 1'b1, '1);
                end
                default:
                begin
                end
            endcase
            add_random(148);
            wait_quiet();
        end

        if (errors == 0 && exp_stamps.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #30000000;
        $display("Verification failed");
        $finish;
    end

endmodule
